// ===== hdl/cvfm_pkg.sv =====
package cvfm_pkg;

  // Frame kinds carried in byte 0.
  localparam logic [7:0] KIND_TEMP  = 8'd1;
  localparam logic [7:0] KIND_BAL   = 8'd2;
  localparam logic [7:0] KIND_CELLS = 8'd4;

  // Lowest reading reported when no cell lies above the threshold.
  localparam logic [13:0] NO_LOW_MV = 14'd10000;
  // Upper edge of the window for highest, average and count.
  localparam logic [15:0] WINDOW_TOP_MV = 16'd5000;

  // Control from the sequencer to the cell store and scan unit.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
  } scan_ctrl_t;

endpackage

// ===== hdl/cvfm_frame_if.sv =====
interface cvfm_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_kind;
  logic [7:0] data_byte_1;
  logic [7:0] data_byte_2;
  logic [7:0] data_byte_3;
  logic [7:0] data_byte_4;
  logic [7:0] data_byte_5;
  logic [7:0] data_byte_6;
  logic [7:0] data_byte_7;

  modport source (
    output valid, frame_kind, data_byte_1, data_byte_2, data_byte_3,
           data_byte_4, data_byte_5, data_byte_6, data_byte_7,
    input  ready
  );
  modport sink (
    input  valid, frame_kind, data_byte_1, data_byte_2, data_byte_3,
           data_byte_4, data_byte_5, data_byte_6, data_byte_7,
    output ready
  );
endinterface

// ===== hdl/cvfm_result_if.sv =====
interface cvfm_result_if;
  logic        valid;
  logic        ready;
  logic [13:0] lowest_cell_mv;
  logic [12:0] highest_cell_mv;
  logic [12:0] average_cell_mv;
  logic [4:0]  valid_cell_count;
  logic [15:0] temperature_raw;
  logic [7:0]  balance_status;

  modport source (
    output valid, lowest_cell_mv, highest_cell_mv, average_cell_mv,
           valid_cell_count, temperature_raw, balance_status,
    input  ready
  );
  modport sink (
    input  valid, lowest_cell_mv, highest_cell_mv, average_cell_mv,
           valid_cell_count, temperature_raw, balance_status,
    output ready
  );
endinterface

// ===== hdl/cvfm_cfg_if.sv =====
interface cvfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] ignore_threshold_mv;

  modport source (output valid, ignore_threshold_mv, input ready);
  modport sink (input valid, ignore_threshold_mv, output ready);
endinterface

// ===== hdl/cvfm_cell_scan.sv =====
module cvfm_cell_scan #(
  parameter int CellCount = 24,
  parameter int AddrW     = $clog2(CellCount),
  parameter int SumW      = $clog2(CellCount * 5000),
  parameter int CntW      = $clog2(CellCount + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cvfm_pkg::scan_ctrl_t    ctrl_i,
  input  logic [AddrW-1:0]        wr_addr_i,
  input  logic [15:0]             wr_data_i,
  input  logic [AddrW-1:0]        rd_addr_i,
  input  logic [12:0]             thr_i,
  output logic [13:0]             low_o,
  output logic [12:0]             high_o,
  output logic [SumW-1:0]         sum_o,
  output logic [CntW-1:0]         count_o
);
  import cvfm_pkg::*;

  logic [15:0]          mem [CellCount];
  logic [15:0]          rd_data_q;
  logic [CellCount-1:0] valid_q;
  logic                 rd_valid_q;
  logic                 acc_en_q;

  logic [13:0]          low_q;
  logic [12:0]          high_q;
  logic [SumW-1:0]      sum_q;
  logic [CntW-1:0]      count_q;

  logic [15:0]          cell_v;
  logic                 above_thr;
  logic                 in_window;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      acc_en_q   <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
      acc_en_q   <= ctrl_i.rd_en;
    end
  end

  assign cell_v    = rd_valid_q ? rd_data_q : 16'd0;
  assign above_thr = cell_v > {3'd0, thr_i};
  assign in_window = above_thr && (cell_v < WINDOW_TOP_MV);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      low_q   <= NO_LOW_MV;
      high_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (acc_en_q) begin
      if (above_thr && (cell_v < {2'd0, low_q})) begin
        low_q <= cell_v[13:0];
      end
      if (in_window) begin
        count_q <= count_q + CntW'(1);
        sum_q   <= sum_q + SumW'(cell_v[12:0]);
        if (cell_v[12:0] > high_q) begin
          high_q <= cell_v[12:0];
        end
      end
    end
  end

  assign low_o   = low_q;
  assign high_o  = high_q;
  assign sum_o   = sum_q;
  assign count_o = count_q;

endmodule

// ===== hdl/cvfm_divider.sv =====
module cvfm_divider #(
  parameter int DvdW = 17,
  parameter int DvsW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);
  localparam int StepW = $clog2(DvdW + 1);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [DvdW-1:0]  quo_q;
  logic [DvsW-1:0]  rem_q;
  logic [DvsW-1:0]  dvs_q;
  logic [DvsW:0]    trial;
  logic             fits;

  // One quotient bit per cycle, most significant first.
  assign trial = {rem_q, quo_q[DvdW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(DvdW);
    end else if (busy_q) begin
      step_q <= step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DvdW-2:0], fits};
      rem_q <= fits ? DvsW'(trial - {1'b0, dvs_q}) : DvsW'(trial);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/cell_voltage_frame_monitor.sv =====
// Battery-module frame monitor. Each accepted frame updates the stored temperature
// word, the balance-status byte or up to three cell readings, and then yields one
// result with the lowest, highest and mean cell voltage, the in-window cell count
// and the stored temperature and balance status. After a frame is taken, the
// write phase writes the cell slots through the single store write port, the
// store is scanned cell by cell through one compare-and-accumulate unit, and a
// bit-serial divider forms the mean one quotient bit per cycle. The cell store is
// cleared at reset by per-entry valid bits, so the block is ready right after
// reset. A finished result waits in an output register while the next frame is
// taken.
module cell_voltage_frame_monitor #(
  parameter int CELL_COUNT = 24
) (
  input logic          clk_i,
  input logic          rst_ni,
  cvfm_cfg_if.sink     cfg_i,
  cvfm_frame_if.sink   frame_i,
  cvfm_result_if.source result_o
);
  import cvfm_pkg::*;

  localparam int AddrW = $clog2(CELL_COUNT);
  localparam int SumW  = $clog2(CELL_COUNT * 5000);
  localparam int CntW  = $clog2(CELL_COUNT + 1);
  localparam int CtrW  = $clog2(CELL_COUNT + 2);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CtrW-1:0]  cnt_q, cnt_d;
  logic [12:0]      thr_q;
  logic [15:0]      temp_q;
  logic [7:0]       bal_q;
  logic             cells_q;
  logic [7:0]       b1_q, b2_q, b3_q, b4_q, b5_q, b6_q, b7_q;

  logic             frame_xfer;
  logic             load_res;
  logic             out_valid_q;
  logic [13:0]      low_res_q;
  logic [12:0]      high_res_q;
  logic [12:0]      avg_res_q;
  logic [4:0]       cnt_res_q;
  logic [15:0]      temp_res_q;
  logic [7:0]       bal_res_q;

  scan_ctrl_t       ctrl;
  logic [8:0]       slot_idx;
  logic             slot_ok;
  logic [15:0]      slot_data;
  logic [13:0]      scan_low;
  logic [12:0]      scan_high;
  logic [SumW-1:0]  scan_sum;
  logic [CntW-1:0]  scan_count;
  logic             div_start;
  logic             div_done;
  logic [SumW-1:0]  div_quo;

  assign cfg_i.ready   = 1'b1;
  assign frame_i.ready = state_q == S_IDLE;
  assign frame_xfer    = frame_i.valid && frame_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      temp_q <= '0;
      bal_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        thr_q <= cfg_i.ignore_threshold_mv;
      end
      if (frame_xfer && frame_i.frame_kind == KIND_TEMP) begin
        temp_q <= {frame_i.data_byte_1, frame_i.data_byte_2};
      end
      if (frame_xfer && frame_i.frame_kind == KIND_BAL) begin
        bal_q <= frame_i.data_byte_3;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_xfer) begin
      cells_q <= frame_i.frame_kind == KIND_CELLS;
      b1_q    <= frame_i.data_byte_1;
      b2_q    <= frame_i.data_byte_2;
      b3_q    <= frame_i.data_byte_3;
      b4_q    <= frame_i.data_byte_4;
      b5_q    <= frame_i.data_byte_5;
      b6_q    <= frame_i.data_byte_6;
      b7_q    <= frame_i.data_byte_7;
    end
  end

  // Slot k of a cell frame goes to index byte1 + k and is dropped past the end.
  assign slot_idx = {1'b0, b1_q} + {7'd0, cnt_q[1:0]};
  assign slot_ok  = slot_idx < 9'(CELL_COUNT);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    slot_data = {b2_q, b3_q};
      2'd1:    slot_data = {b4_q, b5_q};
      default: slot_data = {b6_q, b7_q};
    endcase
  end

  always_comb begin
    ctrl.wr_en = (state_q == S_WRITE) && cells_q && slot_ok;
    ctrl.rd_en = (state_q == S_SCAN) && (cnt_q < CtrW'(CELL_COUNT));
    ctrl.clr   = state_q == S_WRITE;
  end

  // The last accumulation lands in the cycle after the last read, so the divider
  // starts on the cycle after that.
  assign div_start = (state_q == S_SCAN) && (cnt_q == CtrW'(CELL_COUNT + 1));
  assign load_res  = (state_q == S_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (frame_xfer) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (cnt_q == CtrW'(2)) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CtrW'(1);
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + CtrW'(1);
        if (div_start) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_res) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      low_res_q  <= scan_low;
      high_res_q <= scan_high;
      avg_res_q  <= (scan_count == '0) ? 13'd0 : 13'(div_quo);
      cnt_res_q  <= 5'(scan_count);
      temp_res_q <= temp_q;
      bal_res_q  <= bal_q;
    end
  end

  cvfm_cell_scan #(
    .CellCount (CELL_COUNT),
    .AddrW     (AddrW),
    .SumW      (SumW),
    .CntW      (CntW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .wr_addr_i (AddrW'(slot_idx)),
    .wr_data_i (slot_data),
    .rd_addr_i (AddrW'(cnt_q)),
    .thr_i     (thr_q),
    .low_o     (scan_low),
    .high_o    (scan_high),
    .sum_o     (scan_sum),
    .count_o   (scan_count)
  );

  cvfm_divider #(
    .DvdW (SumW),
    .DvsW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scan_sum),
    .divisor_i  (scan_count),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign result_o.valid            = out_valid_q;
  assign result_o.lowest_cell_mv   = low_res_q;
  assign result_o.highest_cell_mv  = high_res_q;
  assign result_o.average_cell_mv  = avg_res_q;
  assign result_o.valid_cell_count = cnt_res_q;
  assign result_o.temperature_raw  = temp_res_q;
  assign result_o.balance_status   = bal_res_q;

  a_xfer_starts_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_xfer |=> state_q == S_WRITE)
    else $error("frame transfer did not start the write phase");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide phase");

  a_avg_not_above_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> avg_res_q <= high_res_q)
    else $error("average exceeds highest cell");

  a_low_not_above_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && high_res_q != 13'd0) |-> low_res_q <= {1'b0, high_res_q})
    else $error("lowest cell above highest cell");

endmodule
